>>> hw/rtl/collision_warning_ttc_classifier_macros.svh
// ----------------------------------------------------------------------------
// Collision warning TTC classifier - assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef COLLISION_WARNING_TTC_CLASSIFIER_MACROS_SVH
`define COLLISION_WARNING_TTC_CLASSIFIER_MACROS_SVH

// same-cycle implication
`define CWTC_ASSERT_IMP(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define CWTC_ASSERT_NXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> hw/rtl/cwtc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Collision warning TTC classifier - package
// Widths, register codes, reset values and shared types.
// ----------------------------------------------------------------------------
package cwtc_pkg;

	localparam int SPEED_WIDTH_DEF = 21;
	localparam int DIST_W          = 16;
	localparam int TTC_W           = 16;
	localparam int RAW_W           = 21;
	localparam int OUT_SPEED_W     = 21;
	localparam int QUO_W           = DIST_W + 8;
	localparam int GAIN_W          = 9;
	localparam int MUL_B_W         = GAIN_W + 1;
	localparam int HOLD_W          = 4;
	localparam int CFG_IDX_W       = 3;
	localparam int CFG_DATA_W      = 16;
	localparam int FRAC_SHIFT      = 8;

	localparam logic [TTC_W-1:0]  TTC_NONE   = 16'hFFFF;
	localparam logic [TTC_W-1:0]  TTC_MAX    = 16'hFFFE;
	localparam logic [GAIN_W-1:0] GAIN_ONE   = 9'd256;
	localparam int                RAW_SCALE  = 10;
	localparam int                ROUND_BIAS = 128;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_DANGER_ENTER = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_DANGER_EXIT  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_WARNING      = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_DANGER_HOLD  = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_MIN_SPEED    = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_FILTER_GAIN  = 3'd5;

	// register reset values
	localparam logic [TTC_W-1:0]  RST_DANGER_ENTER = 16'd384;
	localparam logic [TTC_W-1:0]  RST_DANGER_EXIT  = 16'd307;
	localparam logic [TTC_W-1:0]  RST_WARNING      = 16'd1280;
	localparam logic [HOLD_W-1:0] RST_DANGER_HOLD  = 4'd8;
	localparam logic [15:0]       RST_MIN_SPEED    = 16'd16;
	localparam logic [GAIN_W-1:0] RST_FILTER_GAIN  = 9'd102;

	typedef enum logic [1:0] {
		WS_SAFE    = 2'd0,
		WS_WARNING = 2'd1,
		WS_DANGER  = 2'd2
	} warn_t;

	typedef enum logic [2:0] {
		CS_IDLE,
		CS_DIFF,
		CS_MUL_G,
		CS_MUL_F,
		CS_SAT,
		CS_CHK,
		CS_DIV,
		CS_DONE
	} ctrl_state_t;

	typedef struct packed {
		logic busy;
		logic done;
	} div_stat_t;

endpackage

>>> hw/rtl/cwtc_mac.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Collision warning TTC classifier - shared multiply-accumulate unit
// One signed multiplier with an adder, result registered on enable.
// ----------------------------------------------------------------------------
module cwtc_mac
	import cwtc_pkg::*;
#(
	parameter int AW    = RAW_W,
	parameter int ACC_W = RAW_W + MUL_B_W + 1
) (
	input  logic                    clk,
	input  logic                    en,
	input  logic signed [AW-1:0]    op_a,
	input  logic signed [MUL_B_W-1:0] op_b,
	input  logic signed [ACC_W-1:0] addend,
	output logic signed [ACC_W-1:0] acc
);

	logic signed [AW+MUL_B_W-1:0] prod;
	logic signed [ACC_W-1:0]      acc_q;

	assign prod = op_a * op_b;

	always_ff @(posedge clk) begin
		if (en) begin
			acc_q <= ACC_W'(prod) + addend;
		end
	end

	assign acc = acc_q;

endmodule

>>> hw/rtl/cwtc_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Collision warning TTC classifier - bit-serial divider
// Restoring division, one quotient bit per cycle, QUO_W quotient bits per divide.
// ----------------------------------------------------------------------------
module cwtc_div
	import cwtc_pkg::*;
#(
	parameter int DIVISOR_W = SPEED_WIDTH_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	input  logic [QUO_W-1:0]     dividend,
	input  logic [DIVISOR_W-1:0] divisor,
	output logic [QUO_W-1:0]     quotient,
	output div_stat_t            stat
);

	localparam int CNT_W = $clog2(QUO_W);

	logic                 busy_q;
	logic                 done_q;
	logic [CNT_W-1:0]     cnt_q;
	logic [DIVISOR_W-1:0] rem_q;
	logic [DIVISOR_W-1:0] dvs_q;
	logic [QUO_W-1:0]     quo_q;
	logic [DIVISOR_W:0]   rem_sh;
	logic [DIVISOR_W:0]   rem_nx;
	logic                 ge;

	assign rem_sh = {rem_q, quo_q[QUO_W-1]};
	assign ge     = rem_sh >= {1'b0, dvs_q};
	assign rem_nx = ge ? (rem_sh - {1'b0, dvs_q}) : rem_sh;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CNT_W'(QUO_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
			dvs_q <= divisor;
		end else if (busy_q) begin
			rem_q <= rem_nx[DIVISOR_W-1:0];
			quo_q <= {quo_q[QUO_W-2:0], ge};
		end
	end

	assign quotient  = quo_q;
	assign stat.busy = busy_q;
	assign stat.done = done_q;

endmodule

>>> hw/rtl/collision_warning_ttc_classifier.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Collision warning TTC classifier - top level
// Speed estimate, IIR filter, time to collision and safe/warning/danger FSM.
// ----------------------------------------------------------------------------
// One range sample is taken per transaction and gives one result. The block
// is busy while a sample is processed: the shared multiplier runs three
// passes (difference scaling, new-estimate weight, old-estimate weight),
// followed by a saturate step and a closing-speed check. When the object is
// closing faster than min_closing_speed, a bit-serial divider produces the
// time to collision, one quotient bit per cycle. The result then waits in
// the done step until the previous result has been taken. Configuration
// writes are always accepted and must be issued while the block is idle.
`include "collision_warning_ttc_classifier_macros.svh"

module collision_warning_ttc_classifier
	import cwtc_pkg::*;
#(
	parameter int SPEED_WIDTH = SPEED_WIDTH_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	output logic                   in_ready,
	input  logic [DIST_W-1:0]      distance,
	output logic                   out_valid,
	input  logic                   out_ready,
	output logic [1:0]             warn_state,
	output logic [TTC_W-1:0]       time_to_collision,
	output logic [OUT_SPEED_W-1:0] speed_filt,
	input  logic                   cfg_valid,
	output logic                   cfg_ready,
	input  logic [CFG_IDX_W-1:0]   cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_data
);

	localparam int W     = SPEED_WIDTH;
	localparam int AW    = (SPEED_WIDTH > RAW_W) ? SPEED_WIDTH : RAW_W;
	localparam int ACC_W = AW + MUL_B_W + 1;

	// configuration
	logic [TTC_W-1:0]  enter_q;
	logic [TTC_W-1:0]  exit_q;
	logic [TTC_W-1:0]  warn_q;
	logic [HOLD_W-1:0] hold_cfg_q;
	logic [15:0]       vmin_q;
	logic [GAIN_W-1:0] gain_q;

	// sample state
	ctrl_state_t       state_q, state_nx;
	logic [DIST_W-1:0] dist_q;
	logic [DIST_W-1:0] prev_q;
	logic signed [W-1:0] fs_q;
	warn_t             cur_q, cur_nx;
	logic [HOLD_W-1:0] hold_q, hold_nx;
	logic              closing_q;

	// result register
	logic                   out_valid_q;
	logic [1:0]             ws_out_q;
	logic [TTC_W-1:0]       ttc_out_q;
	logic [OUT_SPEED_W-1:0] spd_out_q;

	// datapath
	logic                    mac_en;
	logic signed [AW-1:0]    mac_a;
	logic signed [MUL_B_W-1:0] mac_b;
	logic signed [ACC_W-1:0] mac_add;
	logic signed [ACC_W-1:0] mac_acc;
	logic [GAIN_W-1:0]       g;
	logic signed [DIST_W:0]  diff_s;
	logic signed [ACC_W-1:0] sh;
	logic signed [W-1:0]     fs_sat;
	logic signed [W:0]       closing_s;
	logic                    closing_c;
	logic                    div_start;
	logic [QUO_W-1:0]        quo;
	div_stat_t               div_stat;
	logic [TTC_W-1:0]        ttc_c;
	logic                    keep;
	logic                    load_out;
	logic signed [AW-1:0]    fs_ext;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enter_q    <= RST_DANGER_ENTER;
			exit_q     <= RST_DANGER_EXIT;
			warn_q     <= RST_WARNING;
			hold_cfg_q <= RST_DANGER_HOLD;
			vmin_q     <= RST_MIN_SPEED;
			gain_q     <= RST_FILTER_GAIN;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_DANGER_ENTER: enter_q    <= cfg_data;
				REG_DANGER_EXIT:  exit_q     <= cfg_data;
				REG_WARNING:      warn_q     <= cfg_data;
				REG_DANGER_HOLD:  hold_cfg_q <= cfg_data[HOLD_W-1:0];
				REG_MIN_SPEED:    vmin_q     <= cfg_data;
				REG_FILTER_GAIN:  gain_q     <= cfg_data[GAIN_W-1:0];
				default: begin
				end
			endcase
		end
	end

	// gain above one is treated as one
	assign g      = (gain_q > GAIN_ONE) ? GAIN_ONE : gain_q;
	assign diff_s = $signed({1'b0, dist_q}) - $signed({1'b0, prev_q});

	// floor divide by 256 is an arithmetic shift
	assign sh = mac_acc >>> FRAC_SHIFT;

	always_comb begin
		if ((sh[ACC_W-1:W-1] == '0) || (sh[ACC_W-1:W-1] == '1)) begin
			fs_sat = sh[W-1:0];
		end else if (sh[ACC_W-1]) begin
			fs_sat = {1'b1, {(W-1){1'b0}}};
		end else begin
			fs_sat = {1'b0, {(W-1){1'b1}}};
		end
	end

	assign closing_s = -((W+1)'(fs_q));
	assign closing_c = closing_s > $signed((W+1)'(vmin_q));

	cwtc_mac #(
		.AW    (AW),
		.ACC_W (ACC_W)
	) u_mac (
		.clk    (clk),
		.en     (mac_en),
		.op_a   (mac_a),
		.op_b   (mac_b),
		.addend (mac_add),
		.acc    (mac_acc)
	);

	cwtc_div #(
		.DIVISOR_W (W)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend ({dist_q, 8'd0}),
		.divisor  (closing_s[W-1:0]),
		.quotient (quo),
		.stat     (div_stat)
	);

	// time to collision and classification
	always_comb begin
		if (!closing_q) begin
			ttc_c = TTC_NONE;
		end else if (quo > QUO_W'(TTC_MAX)) begin
			ttc_c = TTC_MAX;
		end else begin
			ttc_c = quo[TTC_W-1:0];
		end

		keep    = 1'b0;
		cur_nx  = cur_q;
		hold_nx = hold_q;
		if (cur_q == WS_DANGER) begin
			if (hold_q != '0) begin
				hold_nx = hold_q - 1'b1;
				keep    = 1'b1;
			end else if ((ttc_c != '0) && (ttc_c < exit_q)) begin
				keep = 1'b1;
			end
		end
		if (!keep) begin
			if ((ttc_c != '0) && (ttc_c < enter_q)) begin
				cur_nx  = WS_DANGER;
				hold_nx = hold_cfg_q;
			end else if (ttc_c < warn_q) begin
				cur_nx = WS_WARNING;
			end else begin
				cur_nx = WS_SAFE;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= CS_IDLE;
		end else begin
			state_q <= state_nx;
		end
	end

	always_comb begin
		state_nx  = state_q;
		in_ready  = 1'b0;
		mac_en    = 1'b0;
		mac_a     = '0;
		mac_b     = '0;
		mac_add   = '0;
		div_start = 1'b0;
		load_out  = 1'b0;
		case (state_q)
			CS_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					state_nx = CS_DIFF;
				end
			end
			CS_DIFF: begin
				mac_en   = 1'b1;
				mac_a    = AW'(diff_s);
				mac_b    = MUL_B_W'(RAW_SCALE);
				state_nx = CS_MUL_G;
			end
			CS_MUL_G: begin
				// new estimate times its weight
				mac_en   = 1'b1;
				mac_a    = mac_acc[AW-1:0];
				mac_b    = $signed({1'b0, g});
				state_nx = CS_MUL_F;
			end
			CS_MUL_F: begin
				// old estimate times the complement, plus rounding
				mac_en   = 1'b1;
				mac_a    = AW'(fs_q);
				mac_b    = $signed({1'b0, GAIN_ONE - g});
				mac_add  = mac_acc + ACC_W'(ROUND_BIAS);
				state_nx = CS_SAT;
			end
			CS_SAT: begin
				state_nx = CS_CHK;
			end
			CS_CHK: begin
				div_start = closing_c;
				state_nx  = closing_c ? CS_DIV : CS_DONE;
			end
			CS_DIV: begin
				if (div_stat.done) begin
					state_nx = CS_DONE;
				end
			end
			CS_DONE: begin
				if (!out_valid_q || out_ready) begin
					load_out = 1'b1;
					state_nx = CS_IDLE;
				end
			end
			default: begin
				state_nx = CS_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			dist_q <= distance;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_q    <= '0;
			fs_q      <= '0;
			cur_q     <= WS_SAFE;
			hold_q    <= '0;
			closing_q <= 1'b0;
		end else begin
			if (state_q == CS_SAT) begin
				fs_q   <= fs_sat;
				prev_q <= dist_q;
			end
			if (state_q == CS_CHK) begin
				closing_q <= closing_c;
			end
			if (load_out) begin
				cur_q  <= cur_nx;
				hold_q <= hold_nx;
			end
		end
	end

	assign fs_ext = AW'(fs_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_out) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			ws_out_q  <= cur_nx;
			ttc_out_q <= ttc_c;
			spd_out_q <= fs_ext[OUT_SPEED_W-1:0];
		end
	end

	assign out_valid         = out_valid_q;
	assign warn_state        = ws_out_q;
	assign time_to_collision = ttc_out_q;
	assign speed_filt        = spd_out_q;

	`CWTC_ASSERT_IMP(a_hold_only_in_danger, hold_q != '0, cur_q == WS_DANGER, "hold count running outside danger")
	`CWTC_ASSERT_IMP(a_div_in_div_state, div_stat.busy || div_stat.done, state_q == CS_DIV, "divider active outside divide step")
	`CWTC_ASSERT_NXT(a_accept_starts, in_valid && in_ready, state_q == CS_DIFF, "accepted sample did not start processing")
	`CWTC_ASSERT_IMP(a_closing_has_ttc, state_q == CS_DONE && closing_q, ttc_c != TTC_NONE, "closing object reported as not approaching")

endmodule

>>> verif/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Collision warning TTC classifier - testbench
// Drives range samples and register writes over valid/ready channels and
// checks results against script values or a cycle-free model of the speed
// filter, the time to collision and the safe/warning/danger classifier. A
// short directed script comes first, then phases of random approach and
// recede runs under several register settings and flow-control patterns.
// ----------------------------------------------------------------------------
module tb;
	import cwtc_pkg::*;

	localparam int     SCRIPT_LEN   = 25;
	localparam int     PHASES       = 10;
	localparam int     PHASE_ITEMS  = 115;
	localparam int     TAIL_CYCLES  = 40;
	localparam int     CYCLE_LIMIT  = 600000;
	localparam longint SPEED_HI     = (longint'(1) << (SPEED_WIDTH_DEF - 1)) - 1;
	localparam longint SPEED_LO     = -SPEED_HI - 1;
	// addresses past the register list, expected to be ignored
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 3'd6;
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 3'd7;

	typedef struct packed {
		warn_t                  state;
		logic [TTC_W-1:0]       ttc;
		logic [OUT_SPEED_W-1:0] speed;
	} report_t;

	typedef struct packed {
		logic [DIST_W-1:0]      sample;
		logic                   typed;
		warn_t                  state;
		logic [TTC_W-1:0]       ttc;
		logic [OUT_SPEED_W-1:0] speed;
	} script_row_t;

	logic                   clk;
	logic                   arst_n    = 1'b0;
	logic                   in_valid  = 1'b0;
	logic                   in_ready;
	logic [DIST_W-1:0]      distance  = '0;
	logic                   out_valid;
	logic                   out_ready = 1'b0;
	logic [1:0]             warn_state;
	logic [TTC_W-1:0]       time_to_collision;
	logic [OUT_SPEED_W-1:0] speed_filt;
	logic                   cfg_valid = 1'b0;
	logic                   cfg_ready;
	logic [CFG_IDX_W-1:0]   cfg_index = '0;
	logic [CFG_DATA_W-1:0]  cfg_data  = '0;

	// model copy of the registers
	logic [TTC_W-1:0]  cfg_enter     = RST_DANGER_ENTER;
	logic [TTC_W-1:0]  cfg_exit      = RST_DANGER_EXIT;
	logic [TTC_W-1:0]  cfg_warn      = RST_WARNING;
	logic [HOLD_W-1:0] cfg_hold      = RST_DANGER_HOLD;
	logic [15:0]       cfg_min_speed = RST_MIN_SPEED;
	logic [GAIN_W-1:0] cfg_gain      = RST_FILTER_GAIN;

	// model copy of the block state
	logic [DIST_W-1:0] prev_range = '0;
	longint            speed_est  = 0;
	warn_t             alert_q    = WS_SAFE;
	logic [HOLD_W-1:0] hold_left  = '0;

	report_t pending_reports [$];
	int      fail_count     = 0;
	int      cycle_count    = 0;
	int      send_gap_pct   = 0;
	int      sink_stall_pct = 0;

	// random run generator state
	int run_left   = 0;
	int run_pos    = 0;
	int run_stride = 0;

	script_row_t script [SCRIPT_LEN] = '{
		'{16'd0,     1'b1, WS_SAFE, TTC_NONE, 21'd0},
		'{16'd0,     1'b1, WS_SAFE, TTC_NONE, 21'd0},
		'{16'd65535, 1'b0, WS_SAFE, 16'd0,    21'd0},
		'{16'd65535, 1'b0, WS_SAFE, 16'd0,    21'd0},
		'{16'd52000, 1'b0, WS_SAFE, 16'd0,    21'd0},
		'{16'd44000, 1'b0, WS_SAFE, 16'd0,    21'd0},
		'{16'd36000, 1'b0, WS_SAFE, 16'd0,    21'd0},
		'{16'd28000, 1'b0, WS_SAFE, 16'd0,    21'd0},
		'{16'd20000, 1'b0, WS_SAFE, 16'd0,    21'd0},
		'{16'd14000, 1'b0, WS_SAFE, 16'd0,    21'd0},
		'{16'd9000,  1'b0, WS_SAFE, 16'd0,    21'd0},
		'{16'd5000,  1'b0, WS_SAFE, 16'd0,    21'd0},
		'{16'd2500,  1'b0, WS_SAFE, 16'd0,    21'd0},
		'{16'd1000,  1'b0, WS_SAFE, 16'd0,    21'd0},
		'{16'd300,   1'b0, WS_SAFE, 16'd0,    21'd0},
		'{16'd0,     1'b0, WS_SAFE, 16'd0,    21'd0},
		'{16'd0,     1'b0, WS_SAFE, 16'd0,    21'd0},
		'{16'd0,     1'b0, WS_SAFE, 16'd0,    21'd0},
		'{16'd0,     1'b0, WS_SAFE, 16'd0,    21'd0},
		'{16'd0,     1'b0, WS_SAFE, 16'd0,    21'd0},
		'{16'd0,     1'b0, WS_SAFE, 16'd0,    21'd0},
		'{16'd0,     1'b0, WS_SAFE, 16'd0,    21'd0},
		'{16'd0,     1'b0, WS_SAFE, 16'd0,    21'd0},
		'{16'd0,     1'b0, WS_SAFE, 16'd0,    21'd0},
		'{16'd4000,  1'b0, WS_SAFE, 16'd0,    21'd0}
	};

	collision_warning_ttc_classifier u_top (
		.clk               (clk),
		.arst_n            (arst_n),
		.in_valid          (in_valid),
		.in_ready          (in_ready),
		.distance          (distance),
		.out_valid         (out_valid),
		.out_ready         (out_ready),
		.warn_state        (warn_state),
		.time_to_collision (time_to_collision),
		.speed_filt        (speed_filt),
		.cfg_valid         (cfg_valid),
		.cfg_ready         (cfg_ready),
		.cfg_index         (cfg_index),
		.cfg_data          (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// filter, ttc and classifier update for one accepted sample
	function automatic report_t classify_sample(input logic [DIST_W-1:0] d);
		longint  g;
		longint  raw;
		longint  acc;
		longint  fs;
		longint  closing;
		longint  quo;
		logic [TTC_W-1:0] ttc;
		bit      stay;
		report_t r;
		g   = (cfg_gain > GAIN_ONE) ? 256 : longint'(cfg_gain);
		raw = (longint'(d) - longint'(prev_range)) * RAW_SCALE;
		acc = g * raw + (256 - g) * speed_est + ROUND_BIAS;
		fs  = acc >>> FRAC_SHIFT;
		if (fs > SPEED_HI)
			fs = SPEED_HI;
		else if (fs < SPEED_LO)
			fs = SPEED_LO;
		speed_est  = fs;
		prev_range = d;

		closing = -fs;
		if (closing > longint'(cfg_min_speed)) begin
			quo = (longint'(d) << FRAC_SHIFT) / closing;
			ttc = (quo > longint'(TTC_MAX)) ? TTC_MAX : quo[TTC_W-1:0];
		end else begin
			ttc = TTC_NONE;
		end

		stay = 1'b0;
		if (alert_q == WS_DANGER) begin
			if (hold_left != 0) begin
				hold_left = hold_left - 1'b1;
				stay = 1'b1;
			end else if (ttc != 0 && ttc < cfg_exit) begin
				stay = 1'b1;
			end
		end
		if (!stay) begin
			if (ttc != 0 && ttc < cfg_enter) begin
				alert_q   = WS_DANGER;
				hold_left = cfg_hold;
			end else if (ttc < cfg_warn) begin
				alert_q = WS_WARNING;
			end else begin
				alert_q = WS_SAFE;
			end
		end
		r.state = alert_q;
		r.ttc   = ttc;
		r.speed = fs[OUT_SPEED_W-1:0];
		return r;
	endfunction

	// mostly approach and recede runs with jitter, some single noise samples
	function automatic logic [DIST_W-1:0] pick_range();
		int pick;
		int jit;
		int nxt;
		if (run_left == 0) begin
			pick = $urandom_range(0, 99);
			if (pick < 12) begin
				nxt = $urandom_range(0, 65535);
				return nxt[DIST_W-1:0];
			end
			if ($urandom_range(0, 3) == 0)
				run_pos = $urandom_range(0, 65535);
			else
				run_pos = $urandom_range(300, 20000);
			run_stride = $urandom_range(1, 1200);
			if (pick < 80)
				run_stride = -run_stride;
			run_left = $urandom_range(6, 40);
		end
		run_left = run_left - 1;
		jit = $urandom_range(0, 40);
		nxt = run_pos + run_stride + jit - 20;
		if (nxt < 0)
			nxt = 0;
		else if (nxt > 65535)
			nxt = 65535;
		run_pos = nxt;
		return nxt[DIST_W-1:0];
	endfunction

	// leaves in_valid high; the caller lowers it
	task automatic send_range(input logic [DIST_W-1:0] d, input bit typed,
			input report_t want);
		report_t got;
		while ($urandom_range(0, 99) < send_gap_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		distance <= d;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		got = classify_sample(d);
		pending_reports.push_back(typed ? want : got);
	endtask

	task automatic drain_results();
		in_valid <= 1'b0;
		while (pending_reports.size() != 0)
			@(posedge clk);
	endtask

	// leaves cfg_valid high; the caller lowers it
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
			input logic [CFG_DATA_W-1:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		case (idx)
			REG_DANGER_ENTER: cfg_enter     = val;
			REG_DANGER_EXIT:  cfg_exit      = val;
			REG_WARNING:      cfg_warn      = val;
			REG_DANGER_HOLD:  cfg_hold      = val[HOLD_W-1:0];
			REG_MIN_SPEED:    cfg_min_speed = val;
			REG_FILTER_GAIN:  cfg_gain      = val[GAIN_W-1:0];
			default: ;
		endcase
	endtask

	task automatic apply_setting(input int phase);
		logic [CFG_DATA_W-1:0] v_enter;
		logic [CFG_DATA_W-1:0] v_exit;
		logic [CFG_DATA_W-1:0] v_warn;
		logic [CFG_DATA_W-1:0] v_hold;
		logic [CFG_DATA_W-1:0] v_vmin;
		logic [CFG_DATA_W-1:0] v_gain;
		v_enter = $urandom_range(64, 1500);
		v_exit  = $urandom_range(0, v_enter + 300);
		v_warn  = $urandom_range(v_enter, 8000);
		v_hold  = $urandom_range(0, 15);
		v_vmin  = $urandom_range(0, 400);
		v_gain  = $urandom_range(1, 300);
		case (phase)
			0: begin
				v_enter = RST_DANGER_ENTER;
				v_exit  = RST_DANGER_EXIT;
				v_warn  = RST_WARNING;
				v_hold  = RST_DANGER_HOLD;
				v_vmin  = RST_MIN_SPEED;
				v_gain  = RST_FILTER_GAIN;
			end
			1: begin
				{v_enter, v_exit, v_warn, v_hold, v_vmin, v_gain} = '0;
			end
			2: begin
				{v_enter, v_exit, v_warn, v_hold, v_vmin, v_gain} = '1;
			end
			3: begin
				v_hold = 16'd15;
				v_vmin = 16'd0;
				v_gain = GAIN_ONE;
			end
			// gain just above one, clipped to one
			4: v_gain = GAIN_ONE + 1'b1;
			5: v_gain = 16'd1;
			8: begin
				v_enter = $urandom_range(0, 65535);
				v_exit  = $urandom_range(0, 65535);
				v_warn  = $urandom_range(0, 65535);
				v_hold  = $urandom_range(0, 65535);
				v_vmin  = $urandom_range(0, 65535);
				v_gain  = $urandom_range(0, 65535);
			end
			default: ;
		endcase
		write_reg(REG_DANGER_ENTER, v_enter);
		write_reg(REG_DANGER_EXIT, v_exit);
		write_reg(REG_WARNING, v_warn);
		write_reg(REG_DANGER_HOLD, v_hold);
		write_reg(REG_MIN_SPEED, v_vmin);
		write_reg(REG_FILTER_GAIN, v_gain);
		write_reg(REG_SPARE_LO, $urandom_range(0, 65535));
		write_reg(REG_SPARE_HI, $urandom_range(0, 65535));
		cfg_valid <= 1'b0;
	endtask

	// result side: random stalls and comparison with the oldest expectation
	initial begin : result_sink
		report_t want;
		wait (arst_n === 1'b1);
		forever begin
			@(posedge clk);
			if (out_valid === 1'b1 && out_ready) begin
				if (pending_reports.size() == 0) begin
					$error("result transaction with no expectation pending");
					fail_count++;
				end else begin
					want = pending_reports.pop_front();
					if (warn_state !== want.state) begin
						$error("warn_state: expected %0d, got %0d", want.state, warn_state);
						fail_count++;
					end
					if (time_to_collision !== want.ttc) begin
						$error("time_to_collision: expected %0d, got %0d",
							want.ttc, time_to_collision);
						fail_count++;
					end
					if (speed_filt !== want.speed) begin
						$error("speed_filt: expected %0d, got %0d",
							$signed(want.speed), $signed(speed_filt));
						fail_count++;
					end
				end
			end
			out_ready <= ($urandom_range(0, 99) >= sink_stall_pct);
		end
	end

	initial begin : watchdog
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("Some tests failed");
		$finish;
	end

	initial begin : stimulus
		report_t typed_want;
		int      mode;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		for (int i = 0; i < SCRIPT_LEN; i++) begin
			typed_want = '{script[i].state, script[i].ttc, script[i].speed};
			send_range(script[i].sample, script[i].typed, typed_want);
		end

		for (int p = 0; p < PHASES; p++) begin
			drain_results();
			apply_setting(p);
			mode = p % 4;
			send_gap_pct   = (mode == 1) ? 64 : (mode == 3) ? 29 : 0;
			sink_stall_pct = (mode == 2) ? 64 : (mode == 3) ? 29 : 0;
			for (int i = 0; i < PHASE_ITEMS; i++) begin
				// hold the sender off until the pipe is empty once
				if (p == 6 && i == PHASE_ITEMS / 2)
					drain_results();
				send_range(pick_range(), 1'b0, '0);
			end
		end

		drain_results();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (fail_count == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule

>>> filelist.f
+incdir+hw/rtl
hw/rtl/cwtc_pkg.sv
hw/rtl/cwtc_mac.sv
hw/rtl/cwtc_div.sv
hw/rtl/collision_warning_ttc_classifier.sv
verif/tb.sv
